[sv/small_isa_processor_step_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the small ISA processor step block
// Concurrent checks used by small_isa_processor_step.sv.
// ----------------------------------------------------------------------------
`ifndef SMALL_ISA_PROCESSOR_STEP_ASSERT_SVH
`define SMALL_ISA_PROCESSOR_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIPS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIPS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sips_pkg.sv]
// ----------------------------------------------------------------------------
// sips_pkg
// Types, codes and constants of the small ISA processor step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sips_pkg;

  localparam int WORD_W     = 32;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_REGS   = 8;
  localparam int ADDR_IN_W  = 16;
  localparam int OFF_W      = 16;
  localparam int OPC_W      = 3;
  localparam int OPC_LSB    = 22;
  localparam int RA_LSB     = 19;
  localparam int RB_LSB     = 16;
  localparam int RSV_LSB    = 25;
  localparam int MOD_DIGITS = 4;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_EXEC     = 2'd1,
    CMD_READ_REG = 2'd2,
    CMD_READ_MEM = 2'd3
  } cmd_t;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } isa_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_REG_A,
    ST_REG_B,
    ST_ADDR,
    ST_LOAD_WAIT,
    ST_RD_WAIT
  } state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic [ADDR_IN_W-1:0]     mem_address;
    logic [REG_IDX_W-1:0]     reg_index;
    logic signed [WORD_W-1:0] write_data;
  } request_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_data;
    logic [ADDR_IN_W-1:0]     program_counter_out;
    logic                     halted;
    logic [WORD_W-1:0]        executed_count;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] addr;
    logic [WORD_W-1:0]    wdata;
  } rf_cmd_t;

  // Words with any reserved bit set behave as a noop.
  function automatic isa_op_t decode_op(input logic [WORD_W-1:0] ins);
    isa_op_t op;
    if (|ins[WORD_W-1:RSV_LSB]) begin
      op = OP_NOOP;
    end else begin
      op = isa_op_t'(ins[OPC_LSB +: OPC_W]);
    end
    return op;
  endfunction

  function automatic logic [WORD_W-1:0] sext_off(input logic [OFF_W-1:0] v);
    return {{(WORD_W-OFF_W){v[OFF_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

[sv/sips_ram.sv]
// ----------------------------------------------------------------------------
// sips_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sips_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[sv/sips_addr_mod.sv]
// ----------------------------------------------------------------------------
// sips_addr_mod
// Reduces a 32-bit value modulo the memory size, MOD_DIGITS bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sips_addr_mod #(
  parameter int MEM_WORDS = 65536
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [sips_pkg::WORD_W-1:0]      value,
  output logic                                  done,
  output logic      [$clog2(MEM_WORDS)-1:0]     result
);

  localparam int AW    = $clog2(MEM_WORDS);
  localparam int STEPS = sips_pkg::WORD_W / sips_pkg::MOD_DIGITS;
  localparam int CW    = $clog2(STEPS);
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);
  localparam logic [AW:0] MOD_W = (AW+1)'(MEM_WORDS);
  // A power-of-two size is a plain mask and finishes in the cycle after start.
  localparam bit IS_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

  logic                        active;
  logic [CW-1:0]               cnt;
  logic [sips_pkg::WORD_W-1:0] shreg;
  logic [AW-1:0]               rem;
  logic [AW-1:0]               rem_step;

  // Restoring remainder over a few bits: the partial remainder stays below
  // the modulus, so one compare and subtract per bit is enough.
  always_comb begin
    logic [AW:0]   t;
    logic [AW-1:0] r;
    r = rem;
    for (int i = 0; i < sips_pkg::MOD_DIGITS; i++) begin
      t = {r, shreg[sips_pkg::WORD_W-1-i]};
      if (t >= MOD_W) begin
        t = t - MOD_W;
      end
      r = t[AW-1:0];
    end
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= !IS_POW2;
        done   <= IS_POW2;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      rem   <= IS_POW2 ? value[AW-1:0] : '0;
    end else if (active) begin
      shreg <= shreg << sips_pkg::MOD_DIGITS;
      rem   <= rem_step;
    end
  end

  assign result = rem;

endmodule

`default_nettype wire

[sv/sips_regfile.sv]
// ----------------------------------------------------------------------------
// sips_regfile
// Register file on a synchronous RAM; per-entry valid bits give reset zeros.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sips_regfile (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sips_pkg::rf_cmd_t           cmd,
  output logic [sips_pkg::WORD_W-1:0]      rdata
);

  logic [sips_pkg::NUM_REGS-1:0]  valid;
  logic [sips_pkg::REG_IDX_W-1:0] addr_q;
  logic [sips_pkg::WORD_W-1:0]    ram_q;

  sips_ram #(
    .WIDTH (sips_pkg::WORD_W),
    .DEPTH (sips_pkg::NUM_REGS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .addr  (cmd.addr),
    .wdata (cmd.wdata),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.we) begin
      valid[cmd.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    addr_q <= cmd.addr;
  end

  // A register never written since reset reads as zero.
  assign rdata = valid[addr_q] ? ram_q : '0;

endmodule

`default_nettype wire

[sv/small_isa_processor_step.sv]
// ----------------------------------------------------------------------------
// small_isa_processor_step
// Eight-register, word-addressed 32-bit processor that runs one command
// per request: load a memory word, execute one instruction, read a
// register or read a memory word.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Handshake
//   -------   --------------------------   ---------------------------------
//   request   start, busy, request         taken when start = 1 and busy = 0
//   result    done, result                 one-cycle strobe, never held off
//
// A request steps through the states set by the single port of the program
// memory and of the register file: read register ST_RD_WAIT, load ST_ADDR,
// read memory ST_ADDR and ST_RD_WAIT, execute ST_FETCH, ST_REG_A, ST_REG_B,
// then ST_ADDR (sw, taken beq, jalr) or ST_ADDR and ST_LOAD_WAIT (lw); a
// halted execute answers from idle. For a MEM_WORDS that is not a power of
// two, each address reduction waits in ST_ADDR on the serial modulo unit.
// The strobe comes in the cycle after completion, with the next request.
// Synchronous reset clears the control state, pc, the halt flag, the
// count and the register valid bits; program memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "small_isa_processor_step_assert.svh"

module small_isa_processor_step #(
  parameter int MEM_WORDS = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire sips_pkg::request_t   request,
  output logic                      busy,
  output logic                      done,
  output sips_pkg::result_t         result
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int WW = sips_pkg::WORD_W;
  localparam int RW = sips_pkg::REG_IDX_W;

  // Sequencer state and the request held for the length of its work.
  sips_pkg::state_t   state;
  sips_pkg::state_t   state_next;
  sips_pkg::request_t req_q;

  // Architectural state kept in flip-flops.
  logic [AW-1:0] pc;
  logic [AW-1:0] pc_next;
  logic          halt_flag;
  logic          halt_next;
  logic [WW-1:0] count;
  logic [WW-1:0] count_next;
  logic [WW-1:0] count_inc;

  // Instruction word and operands captured from the memories.
  logic [WW-1:0]     ir;
  logic [WW-1:0]     a_val;
  logic [WW-1:0]     b_val;
  sips_pkg::isa_op_t ir_op;
  logic [WW-1:0]     off_ext;
  logic [RW-1:0]     ra_idx;
  logic [RW-1:0]     rb_idx;
  logic [RW-1:0]     rd_idx;
  logic [AW:0]       pc_plus;
  logic [AW-1:0]     pc_inc;

  // Program memory port.
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] mem_rdata;

  // Register file port.
  sips_pkg::rf_cmd_t rf_cmd;
  logic [WW-1:0]     rf_rdata;

  // Address reduction unit.
  logic          mod_start;
  logic [WW-1:0] mod_value;
  logic          mod_done;
  logic [AW-1:0] mod_result;

  logic          finish;
  logic [WW-1:0] fin_rdata;

  sips_ram #(
    .WIDTH (WW),
    .DEPTH (MEM_WORDS)
  ) u_prog_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  sips_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rf_cmd),
    .rdata (rf_rdata)
  );

  sips_addr_mod #(
    .MEM_WORDS (MEM_WORDS)
  ) u_addr_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (mod_value),
    .done   (mod_done),
    .result (mod_result)
  );

  // Instruction fields. The register indexes come from the captured word.
  assign ir_op   = sips_pkg::decode_op(ir);
  assign off_ext = sips_pkg::sext_off(ir[sips_pkg::OFF_W-1:0]);
  assign ra_idx  = ir[sips_pkg::RA_LSB +: RW];
  assign rb_idx  = ir[sips_pkg::RB_LSB +: RW];
  assign rd_idx  = ir[RW-1:0];

  // The pc is always below the memory size, so pc + 1 wraps with a single
  // compare against the size.
  assign pc_plus = {1'b0, pc} + 1'b1;
  assign pc_inc  = (pc_plus == (AW+1)'(MEM_WORDS)) ? '0 : pc_plus[AW-1:0];

  assign count_inc = (count == '1) ? count : count + 1'b1;

  assign busy = (state != sips_pkg::ST_IDLE);

  // Sequencer: fetch, read regA, read regB and execute, then an optional
  // address reduction and data access. Only one request is in flight, so a
  // memory write never overlaps a read of the same entry.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = pc;
    mem_wdata  = req_q.write_data;
    rf_cmd     = '0;
    mod_start  = 1'b0;
    mod_value  = '0;
    finish     = 1'b0;
    fin_rdata  = '0;
    pc_next    = pc;
    halt_next  = halt_flag;
    count_next = count;

    case (state)
      sips_pkg::ST_IDLE: begin
        if (start) begin
          case (sips_pkg::cmd_t'(request.operation))
            sips_pkg::CMD_LOAD, sips_pkg::CMD_READ_MEM: begin
              // The command address may lie beyond the memory size.
              mod_start  = 1'b1;
              mod_value  = WW'(request.mem_address);
              state_next = sips_pkg::ST_ADDR;
            end
            sips_pkg::CMD_READ_REG: begin
              rf_cmd.addr = request.reg_index;
              state_next  = sips_pkg::ST_RD_WAIT;
            end
            sips_pkg::CMD_EXEC: begin
              if (halt_flag) begin
                // A halted processor answers at once and changes nothing.
                finish = 1'b1;
              end else begin
                mem_addr   = pc;
                state_next = sips_pkg::ST_FETCH;
              end
            end
            default: begin
              state_next = sips_pkg::ST_IDLE;
            end
          endcase
        end
      end

      sips_pkg::ST_FETCH: begin
        rf_cmd.addr = mem_rdata[sips_pkg::RA_LSB +: RW];
        state_next  = sips_pkg::ST_REG_A;
      end

      sips_pkg::ST_REG_A: begin
        rf_cmd.addr = rb_idx;
        state_next  = sips_pkg::ST_REG_B;
      end

      sips_pkg::ST_REG_B: begin
        case (ir_op)
          sips_pkg::OP_ADD: begin
            rf_cmd.we    = 1'b1;
            rf_cmd.addr  = rd_idx;
            rf_cmd.wdata = a_val + rf_rdata;
            finish       = 1'b1;
            pc_next      = pc_inc;
            count_next   = count_inc;
          end
          sips_pkg::OP_NOR: begin
            rf_cmd.we    = 1'b1;
            rf_cmd.addr  = rd_idx;
            rf_cmd.wdata = ~(a_val | rf_rdata);
            finish       = 1'b1;
            pc_next      = pc_inc;
            count_next   = count_inc;
          end
          sips_pkg::OP_LW, sips_pkg::OP_SW: begin
            mod_start  = 1'b1;
            mod_value  = a_val + off_ext;
            state_next = sips_pkg::ST_ADDR;
          end
          sips_pkg::OP_BEQ: begin
            if (a_val == rf_rdata) begin
              mod_start  = 1'b1;
              mod_value  = WW'(pc) + WW'(1) + off_ext;
              state_next = sips_pkg::ST_ADDR;
            end else begin
              finish     = 1'b1;
              pc_next    = pc_inc;
              count_next = count_inc;
            end
          end
          sips_pkg::OP_JALR: begin
            // The link goes in first; with regA equal to regB the jump
            // target is therefore the link itself.
            rf_cmd.we    = 1'b1;
            rf_cmd.addr  = rb_idx;
            rf_cmd.wdata = WW'(pc_inc);
            mod_start    = 1'b1;
            mod_value    = (ra_idx == rb_idx) ? WW'(pc_inc) : a_val;
            state_next   = sips_pkg::ST_ADDR;
          end
          sips_pkg::OP_HALT: begin
            halt_next  = 1'b1;
            finish     = 1'b1;
            pc_next    = pc_inc;
            count_next = count_inc;
          end
          default: begin
            finish     = 1'b1;
            pc_next    = pc_inc;
            count_next = count_inc;
          end
        endcase
      end

      sips_pkg::ST_ADDR: begin
        if (mod_done) begin
          if (req_q.operation == sips_pkg::CMD_LOAD) begin
            mem_we    = 1'b1;
            mem_addr  = mod_result;
            mem_wdata = req_q.write_data;
            finish    = 1'b1;
          end else if (req_q.operation == sips_pkg::CMD_READ_MEM) begin
            mem_addr   = mod_result;
            state_next = sips_pkg::ST_RD_WAIT;
          end else begin
            case (ir_op)
              sips_pkg::OP_LW: begin
                mem_addr   = mod_result;
                state_next = sips_pkg::ST_LOAD_WAIT;
              end
              sips_pkg::OP_SW: begin
                mem_we     = 1'b1;
                mem_addr   = mod_result;
                mem_wdata  = b_val;
                finish     = 1'b1;
                pc_next    = pc_inc;
                count_next = count_inc;
              end
              default: begin
                // Taken beq and jalr land on the reduced target.
                finish     = 1'b1;
                pc_next    = mod_result;
                count_next = count_inc;
              end
            endcase
          end
        end
      end

      sips_pkg::ST_LOAD_WAIT: begin
        rf_cmd.we    = 1'b1;
        rf_cmd.addr  = rb_idx;
        rf_cmd.wdata = mem_rdata;
        finish       = 1'b1;
        pc_next      = pc_inc;
        count_next   = count_inc;
      end

      sips_pkg::ST_RD_WAIT: begin
        fin_rdata = (req_q.operation == sips_pkg::CMD_READ_REG) ? rf_rdata : mem_rdata;
        finish    = 1'b1;
      end

      default: begin
        state_next = sips_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      state_next = sips_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sips_pkg::ST_IDLE;
      pc        <= '0;
      halt_flag <= 1'b0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      halt_flag <= halt_next;
      count     <= count_next;
      done      <= finish;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= request;
    end
    if (state == sips_pkg::ST_FETCH) begin
      ir <= mem_rdata;
    end
    if (state == sips_pkg::ST_REG_A) begin
      a_val <= rf_rdata;
    end
    if (state == sips_pkg::ST_REG_B) begin
      b_val <= rf_rdata;
    end
    if (finish) begin
      result.read_data           <= fin_rdata;
      result.program_counter_out <= sips_pkg::ADDR_IN_W'(pc_next);
      result.halted              <= halt_next;
      result.executed_count      <= count_next;
    end
  end

  // The result strobe always falls in a cycle where a new request can go in.
  `SIPS_ASSERT_NOW(a_done_idle, clk, rst, done, state == sips_pkg::ST_IDLE, "done while busy")
  // Once set, the halt flag stays set until reset.
  `SIPS_ASSERT_NEXT(a_halt_sticky, clk, rst, halt_flag, halt_flag, "halt flag dropped")
  // The pc moves only when a request completes.
  `SIPS_ASSERT_NEXT(a_pc_hold, clk, rst, !finish, $stable(pc), "pc moved mid-request")
  // The executed count never goes backward.
  `SIPS_ASSERT_NEXT(a_count_mono, clk, rst, 1'b1, count >= $past(count), "count decreased")

endmodule

`default_nettype wire
